// ===== hw/rtl/eq_pkg.sv =====
// Shared types, constants and helper functions for the Euler angle to quaternion block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package eq_pkg;

    // Fixed field widths and working precision.
    localparam int ANGLE_W   = 20;
    localparam int OUT_W     = 16;
    localparam int WORK_FRAC = 30;
    localparam int WORK_W    = 34;
    localparam int PROD_W    = 2 * WORK_W;

    // Defaults for the top-level parameters.
    localparam int DEF_ANGLE_FRAC_BITS = 16;
    localparam int DEF_OUT_FRAC_BITS   = 14;
    localparam int DEF_CORDIC_STAGES   = 16;

    // Pi scaled by 2^60, and the limit CORDIC gain in Q30.
    localparam logic [63:0] PI_SCALED_60 = 64'h3243F6A8885A308D;

    typedef logic signed [WORK_W-1:0] work_t;

    localparam work_t CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [PROD_W-1:0] MUL_HALF = 68'sd536870912;

    // Rotation sequence codes.
    localparam logic [3:0] SEQ_XYX = 4'd0;
    localparam logic [3:0] SEQ_XYZ = 4'd1;
    localparam logic [3:0] SEQ_XZX = 4'd2;
    localparam logic [3:0] SEQ_XZY = 4'd3;
    localparam logic [3:0] SEQ_YXY = 4'd4;
    localparam logic [3:0] SEQ_YXZ = 4'd5;
    localparam logic [3:0] SEQ_YZX = 4'd6;
    localparam logic [3:0] SEQ_YZY = 4'd7;
    localparam logic [3:0] SEQ_ZXY = 4'd8;
    localparam logic [3:0] SEQ_ZXZ = 4'd9;
    localparam logic [3:0] SEQ_ZYX = 4'd10;
    localparam logic [3:0] SEQ_ZYZ = 4'd11;

    // Input word: three angles and the sequence code.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_first;
        logic signed [ANGLE_W-1:0] angle_second;
        logic signed [ANGLE_W-1:0] angle_third;
        logic        [3:0]         sequence_req;
    } eq_in_t;

    // Result word: the quaternion components.
    typedef struct packed {
        logic signed [OUT_W-1:0] quat_w;
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
    } eq_out_t;

    // Arctangent of 2^-i in Q30, rounded to nearest.
    function automatic work_t atan_q30(input int unsigned idx);
        work_t v;
        case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q30 times Q30, rounded half up back to Q30.
    function automatic work_t mul_q30(input work_t a, input work_t b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b) + MUL_HALF;
        return p[WORK_FRAC +: WORK_W];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/euler_to_quaternion_top.sv =====
// Top level of the Euler angle to unit quaternion converter, all twelve sequences.
// Depends on eq_pkg and eq_angle_unit.
//
// Usage:
//   A word (three Q4.16 angles and a sequence code) is taken at each rising
//   edge where start is high and busy is low. busy never rises, so a new
//   word may be given in every cycle.
//   Each word yields one result word (w,x,y,z in Q2.14), shown on result for
//   exactly one cycle while done is high. Results leave in input order.
//   Each word passes through angle wrapping, the CORDIC stages, two multiply
//   stages, one stage that combines terms per sequence and one for rounding
//   and saturation.
//   Throughput is one word per cycle; the depth of the CORDIC pipeline sets
//   the latency, and every stage takes a new word each cycle.
//   Codes 12 to 15 give an all-zero quaternion.
//   Reset clears the valid pipeline, so no done pulse follows reset until
//   a word is started. The receiver cannot stall; results must be taken
//   in the cycle they appear.
`default_nettype none

module euler_to_quaternion_top
    import eq_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
    parameter int OUT_FRAC_BITS   = DEF_OUT_FRAC_BITS,
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  wire eq_in_t operand,
    output      logic   busy,
    output      logic   done,
    output      eq_out_t result
);

    localparam int LAT_UNIT = CORDIC_STAGES + 3;
    localparam int LATENCY  = LAT_UNIT + 4;
    localparam int SEQ_LEN  = LAT_UNIT + 2;
    localparam int OSH      = WORK_FRAC - OUT_FRAC_BITS;
    localparam logic signed [WORK_W:0] ROUND_C =
        (OSH > 0) ? ((WORK_W+1)'(1) <<< (OSH > 0 ? OSH - 1 : 0)) : '0;
    localparam logic signed [WORK_W:0] OUT_MAX = (WORK_W+1)'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [WORK_W:0] OUT_MIN = -((WORK_W+1)'(1) <<< (OUT_W - 1));

    work_t s1, c1, s2, c2, s3, c3;

    logic       vld_reg [LATENCY];
    logic [3:0] seq_reg [SEQ_LEN];

    work_t pcc_reg, pcs_reg, psc_reg, pss_reg, c2_reg, s2_reg;
    work_t ccc_reg, ccs_reg, scc_reg, scs_reg, csc_reg, css_reg, ssc_reg, sss_reg;
    work_t w_next, x_next, y_next, z_next;
    work_t w_reg, x_reg, y_reg, z_reg;
    eq_out_t result_reg;

    // The pipeline takes a word every cycle.
    assign busy = 1'b0;

    // Three angle lanes.
    eq_angle_unit #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_lane1 (
        .clk      (clk),
        .angle    (operand.angle_first),
        .sin_half (s1),
        .cos_half (c1)
    );

    eq_angle_unit #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_lane2 (
        .clk      (clk),
        .angle    (operand.angle_second),
        .sin_half (s2),
        .cos_half (c2)
    );

    eq_angle_unit #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_lane3 (
        .clk      (clk),
        .angle    (operand.angle_third),
        .sin_half (s3),
        .cos_half (c3)
    );

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LATENCY; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start;
            for (int k = 1; k < LATENCY; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Sequence code delay line, aligned with the products.
    always_ff @(posedge clk)
    begin
        seq_reg[0] <= operand.sequence_req;
        for (int k = 1; k < SEQ_LEN; k++)
        begin
            seq_reg[k] <= seq_reg[k-1];
        end
    end

    // Products of the outer half-angle terms.
    always_ff @(posedge clk)
    begin
        pcc_reg <= mul_q30(c1, c3);
        pcs_reg <= mul_q30(c1, s3);
        psc_reg <= mul_q30(s1, c3);
        pss_reg <= mul_q30(s1, s3);
        c2_reg  <= c2;
        s2_reg  <= s2;
    end

    // Triple products with the middle half-angle terms.
    always_ff @(posedge clk)
    begin
        ccc_reg <= mul_q30(c2_reg, pcc_reg);
        ccs_reg <= mul_q30(c2_reg, pcs_reg);
        scc_reg <= mul_q30(c2_reg, psc_reg);
        scs_reg <= mul_q30(c2_reg, pss_reg);
        csc_reg <= mul_q30(s2_reg, pcc_reg);
        css_reg <= mul_q30(s2_reg, pcs_reg);
        ssc_reg <= mul_q30(s2_reg, psc_reg);
        sss_reg <= mul_q30(s2_reg, pss_reg);
    end

    // Combine the triple products per rotation sequence.
    always_comb
    begin
        w_next = '0;
        x_next = '0;
        y_next = '0;
        z_next = '0;
        unique case (seq_reg[SEQ_LEN-1])
            SEQ_XYX:
            begin
                w_next = ccc_reg - scs_reg; x_next = scc_reg + ccs_reg;
                y_next = csc_reg + sss_reg; z_next = ssc_reg - css_reg;
            end
            SEQ_XYZ:
            begin
                w_next = ccc_reg - sss_reg; x_next = scc_reg + css_reg;
                y_next = csc_reg - scs_reg; z_next = ssc_reg + ccs_reg;
            end
            SEQ_XZX:
            begin
                w_next = ccc_reg - scs_reg; x_next = scc_reg + ccs_reg;
                y_next = css_reg - ssc_reg; z_next = csc_reg + sss_reg;
            end
            SEQ_XZY:
            begin
                w_next = ccc_reg + sss_reg; x_next = scc_reg - css_reg;
                y_next = ccs_reg - ssc_reg; z_next = scs_reg + csc_reg;
            end
            SEQ_YXY:
            begin
                w_next = ccc_reg - scs_reg; x_next = csc_reg + sss_reg;
                y_next = scc_reg + ccs_reg; z_next = css_reg - ssc_reg;
            end
            SEQ_YXZ:
            begin
                w_next = ccc_reg + sss_reg; x_next = scs_reg + csc_reg;
                y_next = scc_reg - css_reg; z_next = ccs_reg - ssc_reg;
            end
            SEQ_YZX:
            begin
                w_next = ccc_reg - sss_reg; x_next = ssc_reg + ccs_reg;
                y_next = scc_reg + css_reg; z_next = csc_reg - scs_reg;
            end
            SEQ_YZY:
            begin
                w_next = ccc_reg - scs_reg; x_next = ssc_reg - css_reg;
                y_next = scc_reg + ccs_reg; z_next = csc_reg + sss_reg;
            end
            SEQ_ZXY:
            begin
                w_next = ccc_reg - sss_reg; x_next = csc_reg - scs_reg;
                y_next = ssc_reg + ccs_reg; z_next = scc_reg + css_reg;
            end
            SEQ_ZXZ:
            begin
                w_next = ccc_reg - scs_reg; x_next = csc_reg + sss_reg;
                y_next = ssc_reg - css_reg; z_next = scc_reg + ccs_reg;
            end
            SEQ_ZYX:
            begin
                w_next = ccc_reg + sss_reg; x_next = ccs_reg - ssc_reg;
                y_next = scs_reg + csc_reg; z_next = scc_reg - css_reg;
            end
            SEQ_ZYZ:
            begin
                w_next = ccc_reg - scs_reg; x_next = css_reg - ssc_reg;
                y_next = csc_reg + sss_reg; z_next = scc_reg + ccs_reg;
            end
            default:
            begin
                w_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // Round half up from Q30 to the output scale and saturate.
    function automatic logic signed [OUT_W-1:0] to_out(input work_t v);
        logic signed [WORK_W:0] r;
        r = ((WORK_W+1)'(v) + ROUND_C) >>> OSH;
        if (r > OUT_MAX)
        begin
            r = OUT_MAX;
        end
        else if (r < OUT_MIN)
        begin
            r = OUT_MIN;
        end
        return r[OUT_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        result_reg.quat_w <= to_out(w_reg);
        result_reg.quat_x <= to_out(x_reg);
        result_reg.quat_y <= to_out(y_reg);
        result_reg.quat_z <= to_out(z_reg);
    end

    assign result = result_reg;
    assign done   = vld_reg[LATENCY-1];

    // Every accepted word comes out a fixed number of cycles later.
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("accepted word did not produce a result on time");

    // No result appears without a word accepted earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LATENCY !done)
        else $error("result strobe without an accepted word");

    // Unknown sequence codes produce a zero quaternion.
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[SEQ_LEN-1] && (seq_reg[SEQ_LEN-1] > SEQ_ZYZ)) |-> ##2
        (done && (result == '0)))
        else $error("unknown sequence gave a nonzero quaternion");

endmodule

`default_nettype wire

// ===== hw/rtl/eq_angle_unit.sv =====
// One angle lane: wraps the angle into (-pi,pi), then runs a pipelined CORDIC
// on the half angle. Depends on eq_pkg.
`default_nettype none

module eq_angle_unit
    import eq_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
)
(
    input  wire logic                      clk,
    input  wire logic signed [ANGLE_W-1:0] angle,
    output      work_t                     sin_half,
    output      work_t                     cos_half
);

    // Pi and one turn at the angle scale, and a reciprocal of the turn.
    localparam int          PI_SH    = 60 - ANGLE_FRAC_BITS;
    localparam logic [63:0] PI_U     = (PI_SCALED_60 + (64'd1 << (PI_SH - 1))) >> PI_SH;
    localparam logic [63:0] TURN_U   = PI_U << 1;
    localparam int          RECIP_SH = 40;
    localparam logic [63:0] RECIP_U  = ((64'd1 << RECIP_SH) + TURN_U - 64'd1) / TURN_U;
    localparam work_t       PI_FIX   = $signed(PI_U[WORK_W-1:0]);
    localparam work_t       TURN     = $signed(TURN_U[WORK_W-1:0]);
    localparam logic signed [31:0] RECIP = $signed({1'b0, RECIP_U[30:0]});
    localparam int          MUL_W    = ANGLE_W + 32;
    localparam int          Q_W      = MUL_W - RECIP_SH;
    localparam int          Z_SH     = WORK_FRAC - 1 - ANGLE_FRAC_BITS;

    logic signed [MUL_W-1:0]   quot_prod;
    logic signed [ANGLE_W-1:0] t1_reg;
    logic signed [Q_W-1:0]     q_reg;
    work_t                     r_reg;
    logic                      t_neg_reg;
    work_t                     r_plus;
    work_t                     r_minus;
    work_t                     r_mod;
    work_t                     r_fold;
    work_t                     z_next;

    work_t x_reg [CORDIC_STAGES+1];
    work_t y_reg [CORDIC_STAGES+1];
    work_t z_reg [CORDIC_STAGES+1];

    // Turn count estimate: floor of angle times the reciprocal, off by at most one.
    assign quot_prod = MUL_W'(angle) * MUL_W'(RECIP);

    always_ff @(posedge clk)
    begin
        t1_reg <= angle;
        q_reg  <= quot_prod[MUL_W-1:RECIP_SH];
    end

    // Remove the estimated whole turns.
    always_ff @(posedge clk)
    begin
        r_reg     <= WORK_W'(t1_reg) - WORK_W'(q_reg) * TURN;
        t_neg_reg <= t1_reg[ANGLE_W-1];
    end

    // Correct into [0,turn), fold into (-pi,pi], nudge the pi edge inward.
    assign r_plus  = r_reg + TURN;
    assign r_minus = r_reg - TURN;

    always_comb
    begin
        if (r_reg < 0)
        begin
            r_mod = r_plus;
        end
        else if (r_reg >= TURN)
        begin
            r_mod = r_minus;
        end
        else
        begin
            r_mod = r_reg;
        end

        if (r_mod > PI_FIX)
        begin
            r_fold = r_mod - TURN;
        end
        else if (r_mod == PI_FIX)
        begin
            r_fold = t_neg_reg ? (1 - PI_FIX) : (PI_FIX - 1);
        end
        else
        begin
            r_fold = r_mod;
        end

        z_next = r_fold <<< Z_SH;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= CORDIC_GAIN;
        y_reg[0] <= '0;
        z_reg[0] <= z_next;
    end

    // CORDIC rotation stages, one micro-rotation per register stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam work_t ATAN_I = atan_q30(i);

        always_ff @(posedge clk)
        begin
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN_I;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN_I;
            end
        end
    end

    assign sin_half = y_reg[CORDIC_STAGES];
    assign cos_half = x_reg[CORDIC_STAGES];

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for euler_to_quaternion_top: random and corner angle words.
// Depends on eq_pkg and the block's RTL; predicts each quaternion in fixed point.
`default_nettype none

module tb;
    import eq_pkg::*;

    localparam int AFRAC = DEF_ANGLE_FRAC_BITS;
    localparam int OFRAC = DEF_OUT_FRAC_BITS;
    localparam int STAGES = DEF_CORDIC_STAGES;
    localparam int LATENCY = STAGES + 7;

    typedef logic signed [63:0] s64_t;

    logic clk;
    logic rst_n;
    logic start;
    eq_in_t operand;
    logic busy;
    logic done;
    eq_out_t result;

    eq_out_t quat_queue[$];
    int mismatches;

    euler_to_quaternion_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .operand(operand),
        .busy(busy),
        .done(done),
        .result(result)
    );

    // Clock with period 12.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Arctangent of 2^-i in Q30, rounded to nearest.
    function automatic s64_t atan_step(input int i);
        s64_t tbl[32];
        tbl = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                128, 64, 32, 16, 8, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    // Q30 product rounded half up; arithmetic shift is a floor.
    function automatic s64_t qmul(input s64_t a, input s64_t b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Wrap by whole turns into [-pi,pi], then pull exact +/-pi in by one LSB.
    function automatic s64_t wrap_turns(input s64_t t);
        s64_t pi;
        s64_t turn;
        pi = s64_t'((64'h3243F6A8885A308D + (64'd1 << (59 - AFRAC))) >> (60 - AFRAC));
        turn = 2 * pi;
        if (t > pi)
            t -= ((t - pi + turn - 1) / turn) * turn;
        else if (t < -pi)
            t += ((-pi - t + turn - 1) / turn) * turn;
        if (t == pi)
            t = pi - 1;
        else if (t == -pi)
            t = -pi + 1;
        return t;
    endfunction

    // Rotation-mode CORDIC on the half angle.
    function automatic void half_sincos(input s64_t ang, output s64_t s, output s64_t c);
        s64_t z;
        s64_t x;
        s64_t y;
        s64_t dx;
        s64_t dy;
        z = ang <<< (29 - AFRAC);
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
        end
        s = y;
        c = x;
    endfunction

    // Round Q30 to the output format and saturate.
    function automatic logic signed [15:0] to_q14(input s64_t v);
        v = (v + (64'sd1 <<< (29 - OFRAC))) >>> (30 - OFRAC);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // Expected quaternion for one input word.
    function automatic eq_out_t predict_quat(input eq_in_t op);
        s64_t s1, c1, s2, c2, s3, c3;
        s64_t pcc, pcs, psc, pss;
        s64_t ccc, ccs, csc, css, scc, scs, ssc, sss;
        s64_t w, x, y, z;
        eq_out_t q;
        half_sincos(wrap_turns(s64_t'(op.angle_first)), s1, c1);
        half_sincos(wrap_turns(s64_t'(op.angle_second)), s2, c2);
        half_sincos(wrap_turns(s64_t'(op.angle_third)), s3, c3);
        pcc = qmul(c1, c3);
        pcs = qmul(c1, s3);
        psc = qmul(s1, c3);
        pss = qmul(s1, s3);
        ccc = qmul(c2, pcc);
        ccs = qmul(c2, pcs);
        scc = qmul(c2, psc);
        scs = qmul(c2, pss);
        csc = qmul(s2, pcc);
        css = qmul(s2, pcs);
        ssc = qmul(s2, psc);
        sss = qmul(s2, pss);
        w = 0;
        x = 0;
        y = 0;
        z = 0;
        case (op.sequence_req)
            SEQ_XYX: begin w = ccc - scs; x = scc + ccs; y = csc + sss; z = ssc - css; end
            SEQ_XYZ: begin w = ccc - sss; x = scc + css; y = csc - scs; z = ssc + ccs; end
            SEQ_XZX: begin w = ccc - scs; x = scc + ccs; y = css - ssc; z = csc + sss; end
            SEQ_XZY: begin w = ccc + sss; x = scc - css; y = ccs - ssc; z = scs + csc; end
            SEQ_YXY: begin w = ccc - scs; x = csc + sss; y = scc + ccs; z = css - ssc; end
            SEQ_YXZ: begin w = ccc + sss; x = scs + csc; y = scc - css; z = ccs - ssc; end
            SEQ_YZX: begin w = ccc - sss; x = ssc + ccs; y = scc + css; z = csc - scs; end
            SEQ_YZY: begin w = ccc - scs; x = ssc - css; y = scc + ccs; z = csc + sss; end
            SEQ_ZXY: begin w = ccc - sss; x = csc - scs; y = ssc + ccs; z = scc + css; end
            SEQ_ZXZ: begin w = ccc - scs; x = csc + sss; y = ssc - css; z = scc + ccs; end
            SEQ_ZYX: begin w = ccc + sss; x = ccs - ssc; y = scs + csc; z = scc - css; end
            SEQ_ZYZ: begin w = ccc - scs; x = css - ssc; y = csc + sss; z = scc + ccs; end
            default: ;
        endcase
        q.quat_w = to_q14(w);
        q.quat_x = to_q14(x);
        q.quat_y = to_q14(y);
        q.quat_z = to_q14(z);
        return q;
    endfunction

    // Random idle gap: mostly none or short, now and then long.
    // Start drops only when the gap is not empty.
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 55)
            n = 0;
        else if (n < 93)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Send one word and queue its expected quaternion; start stays high after.
    task automatic send_word(input eq_in_t op, input bit with_gap);
        if (with_gap)
            idle_gap();
        start <= 1'b1;
        operand <= op;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        quat_queue.push_back(predict_quat(op));
    endtask

    // Drop start at the end of a burst; it stays low until the next word is sent.
    task automatic stop_sending();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [19:0] rand_angle();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return 20'($urandom_range(0, 2 * 205887) - 205887);
        return 20'($urandom);
    endfunction

    // Corner angles, every sequence and the unknown codes.
    task automatic test_directed();
        logic signed [19:0] corners[8];
        eq_in_t op;
        corners = '{20'sh7FFFF, -20'sh80000, 20'sd0, 20'sd205887, -20'sd205887,
                    20'sd411775, 20'sd102944, -20'sd1};
        for (int s = 0; s < 16; s++)
        begin
            op.angle_first = corners[s % 8];
            op.angle_second = corners[(s + 3) % 8];
            op.angle_third = corners[(s + 5) % 8];
            op.sequence_req = s[3:0];
            send_word(op, 1'b0);
        end
        for (int k = 0; k < 8; k++)
        begin
            op.angle_first = corners[k];
            op.angle_second = corners[k];
            op.angle_third = corners[7 - k];
            op.sequence_req = k[3:0];
            send_word(op, 1'b0);
        end
        stop_sending();
    endtask

    // Random words, with random gaps when gaps is set (back-to-back bursts in between) and back-to-back otherwise.
    task automatic test_random(input int count, input bit gaps);
        eq_in_t op;
        for (int i = 0; i < count; i++)
        begin
            op.angle_first = rand_angle();
            op.angle_second = rand_angle();
            op.angle_third = rand_angle();
            op.sequence_req = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                           : 4'($urandom_range(0, 11));
            send_word(op, gaps);
        end
        stop_sending();
    endtask

    // Hold off until the pipeline has drained, then send 20 back-to-back random words.
    task automatic test_drain_pause();
        while (quat_queue.size() != 0)
            @(posedge clk);
        test_random(20, 1'b0);
    endtask

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        eq_out_t want;
        if (rst_n && done)
        begin
            if (quat_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", result);
            end
            else
            begin
                want = quat_queue.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected w%0d x%0d y%0d z%0d got w%0d x%0d y%0d z%0d",
                                 want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                                 result.quat_w, result.quat_x, result.quat_y,
                                 result.quat_z);
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        mismatches = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operand = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(800, 1'b1);
        test_drain_pause();
        test_random(400, 1'b0);
        test_random(400, 1'b1);
        while (quat_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatches == 0 && quat_queue.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Timeout.
    initial
    begin
        #3000000;
        $display("tb: errors");
        $finish;
    end
endmodule

`default_nettype wire
